// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WMR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define WMR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/wmr_pkg.sv =====
package wmr_pkg;

  localparam int DW = 34;
  localparam int XW = DW + 1;
  localparam int BW = 15;
  localparam int QW = 2 * BW;
  localparam int PW = 2 * QW;
  localparam int SW = PW + 2;
  localparam int NW = 32;
  localparam int EPS_W = 16;
  localparam int DIV_PRESHIFT = 2;

  localparam logic CFG_WEIGHT_MODE = 1'b0;
  localparam logic CFG_EPSILON = 1'b1;

  localparam logic WEIGHT_MODE_RESET = 1'b1;
  localparam logic [EPS_W-1:0] EPSILON_RESET = 16'd17;

  localparam logic signed [31:0] OUT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] OUT_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] center;
    logic               pos;
    logic [DW-1:0]      mag;
  } sb_t;

endpackage

// ===== src/wmr_div.sv =====
module wmr_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic                                         clk,
  input  logic [FRAC_BITS-wmr_pkg::DIV_PRESHIFT:0]     en,
  input  logic [wmr_pkg::NW-1:0]                       s,
  input  logic [wmr_pkg::NW-1:0]                       n,
  output logic [FRAC_BITS-wmr_pkg::DIV_PRESHIFT-1:0]   f
);

  localparam int FW = FRAC_BITS - wmr_pkg::DIV_PRESHIFT;
  localparam int YW = wmr_pkg::NW + 4;
  localparam int RW = YW + 1;

  logic [YW-1:0] y [0:FW];
  logic [RW-1:0] rem [0:FW];
  logic [FW-1:0] quo [0:FW];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y[0]   <= (YW'(s) << 3) + (YW'(s) << 2);
      rem[0] <= RW'({n, {wmr_pkg::DIV_PRESHIFT{1'b0}}});
      quo[0] <= '0;
    end
  end

  for (genvar k = 1; k <= FW; k++) begin : g_step
    logic [RW-1:0] t;
    logic          ge;
    assign t  = {rem[k-1][RW-2:0], 1'b0};
    assign ge = t >= RW'(y[k-1]);
    always_ff @(posedge clk) begin
      if (en[k]) begin
        y[k]   <= y[k-1];
        rem[k] <= ge ? t - RW'(y[k-1]) : t;
        quo[k] <= {quo[k-1][FW-2:0], ge};
      end
    end
  end

  assign f = quo[FW];

endmodule

// ===== src/weno_midpoint_reconstruction.sv =====
// channel  direction  fields                           handshake
// in       input      u_left, u_center, u_right        in_valid / in_ready
// out      output     midpoint_value, saturated        out_valid / out_ready
// cfg      input      cfg_index, cfg_data              cfg_valid / cfg_ready
//
// one transaction per cycle while the output is not stalled
// the restoring divider takes one quotient bit per stage and sets the depth
// reset clears all stage valid bits and loads weight_mode = 1, epsilon = 17
// a stalled output holds its stage, earlier stages keep filling empty slots
// cfg_ready is always high
`include "assert_macros.svh"

module weno_midpoint_reconstruction #(
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                u_left,
  input  logic signed [31:0]                u_center,
  input  logic signed [31:0]                u_right,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                midpoint_value,
  output logic                              saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [wmr_pkg::EPS_W-1:0]         cfg_data
);

  localparam int DW  = wmr_pkg::DW;
  localparam int XW  = wmr_pkg::XW;
  localparam int BW  = wmr_pkg::BW;
  localparam int QW  = wmr_pkg::QW;
  localparam int PW  = wmr_pkg::PW;
  localparam int SW  = wmr_pkg::SW;
  localparam int SQW = 2 * DW - FRAC_BITS;
  localparam int AW  = SQW + 3;
  localparam int HB  = ((SQW + 3) / 4) * 2;
  localparam int XHW = SQW - HB;
  localparam int KD  = HB + 3;
  localparam int FW  = FRAC_BITS - wmr_pkg::DIV_PRESHIFT;
  localparam int PRW = DW + FW;
  localparam int CW  = PRW + 1 - FRAC_BITS;
  localparam int SHW = $clog2(AW + 1);
  localparam int SH2W = $clog2(SW + 1);
  localparam int ST_DIV = 12;
  localparam int ST_MUL = ST_DIV + FW + 1;
  localparam int NS  = ST_MUL + 2;

  localparam logic [HB-1:0]   C3 = HB'(((64'd1 << HB) - 64'd1) / 64'd3);
  localparam logic [HB+1:0]   K3 = (HB + 2)'(((64'd1 << KD) + 64'd1) / 64'd3);

  logic                        weight_mode;
  logic [wmr_pkg::EPS_W-1:0]   epsilon;

  logic [NS-1:0] v, v_next, en, vin;
  logic          hold;

  wmr_pkg::sb_t sb [0:NS-2];

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= wmr_pkg::WEIGHT_MODE_RESET;
      epsilon     <= wmr_pkg::EPSILON_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        wmr_pkg::CFG_WEIGHT_MODE: weight_mode <= cfg_data[0];
        wmr_pkg::CFG_EPSILON:     epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage control
  assign hold = v[NS-1] & ~out_ready;
  assign vin  = {v[NS-2:0], in_valid};

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = !(hold && (&(v | ~({NS{1'b1}} << k))));
    end
    v_next = v;
    for (int k = 0; k < NS; k++) begin
      if (en[k]) v_next[k] = vin[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  // stage 0: differences
  logic signed [XW-1:0] lx, cx, rx, d_lc, d_cr, d_lr, d_2;
  logic [DW-1:0] m_lc, m_cr, m_lr, m_d;

  assign lx   = {{(XW-32){u_left[31]}}, u_left};
  assign cx   = {{(XW-32){u_center[31]}}, u_center};
  assign rx   = {{(XW-32){u_right[31]}}, u_right};
  assign d_lc = lx - cx;
  assign d_cr = cx - rx;
  assign d_lr = lx - rx;
  assign d_2  = lx - (cx <<< 1) + rx;

  logic [DW-1:0] r0_lc, r0_cr, r0_lr, r0_d;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r0_lc <= DW'(d_lc[XW-1] ? -d_lc : d_lc);
      r0_cr <= DW'(d_cr[XW-1] ? -d_cr : d_cr);
      r0_lr <= DW'(d_lr[XW-1] ? -d_lr : d_lr);
      r0_d  <= DW'(d_2[XW-1] ? -d_2 : d_2);
      sb[0].center <= u_center;
      sb[0].pos    <= !d_2[XW-1] && (d_2 != '0);
      sb[0].mag    <= DW'(d_2[XW-1] ? -d_2 : d_2);
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) sb[k] <= sb[k-1];
    end
  end

  // stage 1: squares
  logic [2*DW-1:0] pr_lc, pr_cr, pr_lr, pr_d;
  assign pr_lc = r0_lc * r0_lc;
  assign pr_cr = r0_cr * r0_cr;
  assign pr_lr = r0_lr * r0_lr;
  assign pr_d  = r0_d * r0_d;

  logic [SQW-1:0] r1_s0, r1_s2, r1_lr, r1_d;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r1_s0 <= pr_lc[2*DW-1:FRAC_BITS];
      r1_s2 <= pr_cr[2*DW-1:FRAC_BITS];
      r1_lr <= pr_lr[2*DW-1:FRAC_BITS];
      r1_d  <= pr_d[2*DW-1:FRAC_BITS];
    end
  end

  // stage 2: split floor division by three
  logic [XHW-1:0]    xh;
  logic [HB-1:0]     xl;
  logic [HB:0]       tsum;
  logic [SQW-1:0]    pa_w;
  logic [2*HB+2:0]   tk;

  assign xh   = r1_d[SQW-1:HB];
  assign xl   = r1_d[HB-1:0];
  assign tsum = {1'b0, xl} + (HB + 1)'(xh);
  assign pa_w = xh * C3;
  assign tk   = tsum * K3;

  logic [SQW-1:0] r2_s0, r2_s2, r2_lr4, r2_d, r2_pa;
  logic [HB-1:0]  r2_pb;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      r2_s0  <= r1_s0;
      r2_s2  <= r1_s2;
      r2_lr4 <= r1_lr >> 2;
      r2_d   <= r1_d;
      r2_pa  <= pa_w;
      r2_pb  <= tk[2*HB+2:KD];
    end
  end

  // stage 3: guarded indicators
  logic [AW-1:0] is1, eps_x, lin;
  assign is1   = (AW'(r2_d) << 2) + AW'(r2_pa) + AW'(r2_pb) + AW'(r2_lr4);
  assign eps_x = AW'(epsilon);
  assign lin   = eps_x + (AW'(1) << FRAC_BITS);

  logic [AW-1:0] r3_a0, r3_a1, r3_a2;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r3_a0 <= weight_mode ? eps_x + AW'(r2_s0) : lin;
      r3_a1 <= weight_mode ? eps_x + is1 : lin;
      r3_a2 <= weight_mode ? eps_x + AW'(r2_s2) : lin;
    end
  end

  // stage 4: maximum
  logic [AW-1:0] m01;
  assign m01 = (r3_a1 > r3_a0) ? r3_a1 : r3_a0;

  logic [AW-1:0] r4_a0, r4_a1, r4_a2, r4_mx;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r4_a0 <= r3_a0;
      r4_a1 <= r3_a1;
      r4_a2 <= r3_a2;
      r4_mx <= (r3_a2 > m01) ? r3_a2 : m01;
    end
  end

  // stage 5: scale amount
  logic [SHW-1:0] bl;
  always_comb begin
    bl = '0;
    for (int i = 0; i < AW; i++) begin
      if (r4_mx[i]) bl = SHW'(i + 1);
    end
  end

  logic [AW-1:0]  r5_a0, r5_a1, r5_a2;
  logic [SHW-1:0] r5_sh;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      r5_a0 <= r4_a0;
      r5_a1 <= r4_a1;
      r5_a2 <= r4_a2;
      r5_sh <= (bl > SHW'(BW)) ? bl - SHW'(BW) : '0;
    end
  end

  // stage 6: scaled weights
  logic [AW-1:0] sa0, sa1, sa2;
  logic [BW-1:0] b0, b1, b2;
  assign sa0 = r5_a0 >> r5_sh;
  assign sa1 = r5_a1 >> r5_sh;
  assign sa2 = r5_a2 >> r5_sh;
  assign b0  = (sa0[BW-1:0] == '0) ? BW'(1) : sa0[BW-1:0];
  assign b1  = (sa1[BW-1:0] == '0) ? BW'(1) : sa1[BW-1:0];
  assign b2  = (sa2[BW-1:0] == '0) ? BW'(1) : sa2[BW-1:0];

  logic [BW-1:0] r6_b0, r6_b1, r6_b2;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      r6_b0 <= b0;
      r6_b1 <= b1;
      r6_b2 <= b2;
    end
  end

  // stage 7: squares of scaled weights
  logic [QW-1:0] r7_q0, r7_q1, r7_q2;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      r7_q0 <= r6_b0 * r6_b0;
      r7_q1 <= r6_b1 * r6_b1;
      r7_q2 <= r6_b2 * r6_b2;
    end
  end

  // stage 8: cross products
  logic [PW-1:0] r8_p0, r8_p1, r8_p2;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      r8_p0 <= r7_q1 * r7_q2;
      r8_p1 <= r7_q0 * r7_q2;
      r8_p2 <= r7_q0 * r7_q1;
    end
  end

  // stage 9: denominator and numerator
  logic [SW-1:0] r9_s, r9_n;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      r9_s <= SW'(r8_p0) + (SW'(r8_p1) << 1) + SW'(r8_p2);
      r9_n <= SW'(r8_p1) << 1;
    end
  end

  // stage 10: normalize amount
  logic [SH2W-1:0] bls;
  always_comb begin
    bls = '0;
    for (int i = 0; i < SW; i++) begin
      if (r9_s[i]) bls = SH2W'(i + 1);
    end
  end

  logic [SW-1:0]   r10_s, r10_n;
  logic [SH2W-1:0] r10_sh;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      r10_s  <= r9_s;
      r10_n  <= r9_n;
      r10_sh <= (bls > SH2W'(wmr_pkg::NW)) ? bls - SH2W'(wmr_pkg::NW) : '0;
    end
  end

  // stage 11: normalized operands
  logic [wmr_pkg::NW-1:0] r11_s, r11_n;
  logic [SW-1:0]          s_sh, n_sh;
  assign s_sh = r10_s >> r10_sh;
  assign n_sh = r10_n >> r10_sh;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      r11_s <= s_sh[wmr_pkg::NW-1:0];
      r11_n <= n_sh[wmr_pkg::NW-1:0];
    end
  end

  // stages 12 .. 12 + FW: weight quotient
  logic [FW-1:0] f;

  wmr_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk(clk),
    .en (en[ST_DIV+FW:ST_DIV]),
    .s  (r11_s),
    .n  (r11_n),
    .f  (f)
  );

  // correction product
  logic [PRW-1:0] rm_prod;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      rm_prod <= sb[ST_MUL-1].mag * f;
    end
  end

  // rounding, blend and saturation
  logic [PRW:0]         rnd;
  logic [CW-1:0]        corr;
  logic signed [XW-1:0] cw, crw, res;
  logic                 ovf;

  assign rnd  = {1'b0, rm_prod} + ((PRW + 1)'(1) << (FRAC_BITS - 1));
  assign corr = rnd[PRW:FRAC_BITS];
  assign cw   = {{(XW-32){sb[NS-2].center[31]}}, sb[NS-2].center};
  assign crw  = $signed(XW'(corr));
  assign res  = sb[NS-2].pos ? cw - crw : cw + crw;
  assign ovf  = (res[XW-1:31] != '0) && (res[XW-1:31] != '1);

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      midpoint_value <= ovf ? (res[XW-1] ? wmr_pkg::OUT_MIN : wmr_pkg::OUT_MAX)
                            : res[31:0];
      saturated      <= ovf;
    end
  end

  `WMR_ASSERT_IMP(a_sat_rail, clk, rst, out_valid && saturated, midpoint_value == wmr_pkg::OUT_MAX || midpoint_value == wmr_pkg::OUT_MIN)
  `WMR_ASSERT_IMP(a_ready_stall, clk, rst, !in_ready, out_valid && !out_ready)
  `WMR_ASSERT_IMP(a_quot_range, clk, rst, v[ST_DIV+FW], !f[FW-1])
  `WMR_ASSERT_NXT(a_accept_valid, clk, rst, in_valid && in_ready, v[0])

endmodule
